[design/clb_pkg.sv]
// Shared types, codes and helpers of the concept lattice builder.
// No dependencies; used by clb_engine and concept_lattice_builder_core.
package clb_pkg;

    localparam int MAX_OBJECTS_DEF    = 64;
    localparam int MAX_ATTRIBUTES_DEF = 64;
    localparam int MAX_CONCEPTS_DEF   = 1024;

    localparam int SET_W   = 64;
    localparam int ENTRY_W = 2 * SET_W;
    localparam int TOTAL_W = 11;
    localparam int SIZE_W  = 7;
    localparam int INDEX_W = 10;
    localparam int ATTR_W  = 7;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_LIMIT = 2'd2;
    localparam logic [1:0] STAT_INDEX = 2'd3;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 7'd64;

    // One finished item as the sequencer hands it to the output stage.
    typedef struct packed {
        logic [SET_W-1:0]   extent;
        logic [SET_W-1:0]   intent;
        logic [TOTAL_W-1:0] total;
        logic [1:0]         status;
    } result_t;

    // Population count as a sum of eight byte counts.
    function automatic logic [SIZE_W-1:0] popcount(input logic [SET_W-1:0] v);
        logic [SIZE_W-1:0] sum;
        logic [3:0]        part;
        sum = '0;
        for (int b = 0; b < 8; b++) begin
            part = '0;
            for (int i = 0; i < 8; i++) begin
                part = part + 4'(v[8*b+i]);
            end
            sum = sum + SIZE_W'(part);
        end
        return sum;
    endfunction

endpackage

[design/clb_mem.sv]
// Concept table: one word per concept holding {intent, extent}.
// Synchronous memory, one write and one read port, registered read data.
// Depends on nothing.
module clb_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int WIDTH = 128
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/clb_engine.sv]
// Item sequencer: walks the concept table, searches intents and merges extents.
// Depends on clb_pkg and clb_mem.
module clb_engine #(
    parameter int MAX_OBJECTS  = clb_pkg::MAX_OBJECTS_DEF,
    parameter int MAX_CONCEPTS = clb_pkg::MAX_CONCEPTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    operation,
    input  logic [clb_pkg::SET_W-1:0]     attribute_mask,
    input  logic [clb_pkg::INDEX_W-1:0]   entry_index,
    input  logic [clb_pkg::SET_W-1:0]     used_mask,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_take,
    output clb_pkg::result_t              res
);

    localparam int CW = $clog2(MAX_CONCEPTS + 1);
    localparam int AW = $clog2(MAX_CONCEPTS);
    localparam int OW = $clog2(MAX_OBJECTS + 1);
    localparam int SW = clb_pkg::SET_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OREAD = 3'd1;
    localparam logic [2:0] S_OWAIT = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_RWAIT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [1:0]    status_reg, status_next;
    logic [SW-1:0] mask_reg, mask_next;
    logic [SW-1:0] bit_reg, bit_next;
    logic [SW-1:0] target_reg, target_next;
    logic [SW-1:0] xs_reg, xs_next;
    logic [SW-1:0] ext_res_reg, ext_res_next;
    logic [SW-1:0] int_res_reg, int_res_next;
    logic [CW-1:0] count_reg, count_next;
    logic [OW-1:0] obj_reg, obj_next;
    logic [CW-1:0] outer_reg, outer_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          final_reg, final_next;

    logic                          wr_en, rd_en;
    logic [AW-1:0]                 wr_addr, rd_addr;
    logic [clb_pkg::ENTRY_W-1:0]   wr_data, rd_data;
    logic [SW-1:0]                 rd_intent, rd_extent;
    logic                          match;
    logic                          step_done;
    logic [SW-1:0]                 in_mask;
    logic [SW-1:0]                 in_bit;

    clb_mem #(
        .DEPTH (MAX_CONCEPTS),
        .AW    (AW),
        .WIDTH (clb_pkg::ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_intent = rd_data[clb_pkg::ENTRY_W-1:SW];
    assign rd_extent = rd_data[SW-1:0];
    assign match     = pend_reg && (rd_intent == target_reg);
    assign in_mask   = attribute_mask & used_mask;
    assign in_bit    = SW'(1) << 6'(obj_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        mask_next      = mask_reg;
        bit_next       = bit_reg;
        target_next    = target_reg;
        xs_next        = xs_reg;
        ext_res_next   = ext_res_reg;
        int_res_next   = int_res_reg;
        count_next     = count_reg;
        obj_next       = obj_reg;
        outer_next     = outer_reg;
        limit_next     = limit_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        final_next     = final_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        step_done      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = operation;
                    status_next  = clb_pkg::STAT_OK;
                    ext_res_next = '0;
                    int_res_next = '0;
                    scan_next    = '0;
                    case (operation)
                        clb_pkg::OP_ADD:
                        begin
                            if (32'(obj_reg) >= MAX_OBJECTS)
                            begin
                                status_next = clb_pkg::STAT_LIMIT;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                mask_next  = in_mask;
                                bit_next   = in_bit;
                                limit_next = count_reg;
                                outer_next = '0;
                                if (count_reg == '0)
                                begin
                                    target_next = in_mask;
                                    xs_next     = in_bit;
                                    final_next  = 1'b1;
                                    state_next  = S_SCAN;
                                end
                                else
                                begin
                                    final_next = 1'b0;
                                    state_next = S_OREAD;
                                end
                            end
                        end
                        clb_pkg::OP_CLOSE:
                        begin
                            target_next = used_mask;
                            xs_next     = '0;
                            final_next  = 1'b1;
                            state_next  = S_SCAN;
                        end
                        clb_pkg::OP_READ:
                        begin
                            if ((32'(entry_index) < 32'(count_reg)) &&
                                (32'(entry_index) < MAX_CONCEPTS))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(entry_index);
                                state_next = S_RWAIT;
                            end
                            else
                            begin
                                status_next = clb_pkg::STAT_INDEX;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_OREAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = AW'(outer_reg);
                state_next = S_OWAIT;
            end
            S_OWAIT:
            begin
                target_next = rd_intent & mask_reg;
                xs_next     = rd_extent | bit_reg;
                scan_next   = '0;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (match)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = pend_addr_reg;
                    wr_data   = {rd_intent, rd_extent | xs_reg};
                    step_done = 1'b1;
                end
                else if (!pend_reg && (scan_reg >= count_reg))
                begin
                    if (32'(count_reg) < MAX_CONCEPTS)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(count_reg);
                        wr_data    = {target_reg, xs_reg};
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = clb_pkg::STAT_FULL;
                    end
                    step_done = 1'b1;
                end
                else if (scan_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = AW'(scan_reg);
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(scan_reg);
                    scan_next      = scan_reg + CW'(1);
                end

                if (step_done)
                begin
                    scan_next = '0;
                    if (!final_reg)
                    begin
                        if ((outer_reg + CW'(1)) < limit_reg)
                        begin
                            outer_next = outer_reg + CW'(1);
                            state_next = S_OREAD;
                        end
                        else
                        begin
                            target_next = mask_reg;
                            xs_next     = bit_reg;
                            final_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        if (op_reg == clb_pkg::OP_ADD)
                        begin
                            obj_next = obj_reg + OW'(1);
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_RWAIT:
            begin
                ext_res_next = rd_extent;
                int_res_next = rd_intent;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            obj_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            obj_reg   <= obj_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        status_reg    <= status_next;
        mask_reg      <= mask_next;
        bit_reg       <= bit_next;
        target_reg    <= target_next;
        xs_reg        <= xs_next;
        ext_res_reg   <= ext_res_next;
        int_res_reg   <= int_res_next;
        outer_reg     <= outer_next;
        limit_reg     <= limit_next;
        scan_reg      <= scan_next;
        pend_addr_reg <= pend_addr_next;
        final_reg     <= final_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.extent = ext_res_reg;
    assign res.intent = int_res_reg;
    assign res.total  = clb_pkg::TOTAL_W'(count_reg);
    assign res.status = status_reg;

endmodule

[design/concept_lattice_builder_core.sv]
// Top level of the concept lattice builder: handshakes, configuration, output stage.
// Depends on clb_pkg and clb_engine (which holds clb_mem).
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+------------------------------------------
//  item     | item_valid / item_stall     | operation, attribute_mask, entry_index
//  result   | result_valid / result_stall | extent_bits, intent_bits, extent_size,
//           |                             | intent_size, concept_total, status
//  config   | config_write                | config_data (attribute_count)
//
// A read item reads one table entry; a close item scans the table, where N concepts are stored.
// An add item visits each of the N stored concepts and searches the table for the
// intersected intent, one memory read per cycle; the single read port of the concept
// memory sets that pace.
// Reset clears the counters and the control state; the concept memory is not cleared,
// since only entries below the concept count are ever read.
// One item is in work at a time; a finished result waits in the output register while
// the next item is taken, and the sequencer holds its result while that register is full and stalled.
module concept_lattice_builder_core #(
    parameter int MAX_OBJECTS    = clb_pkg::MAX_OBJECTS_DEF,
    parameter int MAX_ATTRIBUTES = clb_pkg::MAX_ATTRIBUTES_DEF,
    parameter int MAX_CONCEPTS   = clb_pkg::MAX_CONCEPTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          config_write,
    input  logic [clb_pkg::ATTR_W-1:0]    config_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    operation,
    input  logic [clb_pkg::SET_W-1:0]     attribute_mask,
    input  logic [clb_pkg::INDEX_W-1:0]   entry_index,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [clb_pkg::SET_W-1:0]     extent_bits,
    output logic [clb_pkg::SET_W-1:0]     intent_bits,
    output logic [clb_pkg::SIZE_W-1:0]    extent_size,
    output logic [clb_pkg::SIZE_W-1:0]    intent_size,
    output logic [clb_pkg::TOTAL_W-1:0]   concept_total,
    output logic [1:0]                    status
);

    logic [clb_pkg::ATTR_W-1:0]  attr_reg;
    logic [clb_pkg::ATTR_W-1:0]  attr_used;
    logic [clb_pkg::SET_W-1:0]   used_mask;
    logic                        engine_idle;
    logic                        res_valid;
    logic                        res_take;
    logic                        start;
    clb_pkg::result_t            res;

    logic                        out_valid_reg;
    logic [clb_pkg::SET_W-1:0]   extent_reg;
    logic [clb_pkg::SET_W-1:0]   intent_reg;
    logic [clb_pkg::SIZE_W-1:0]  extent_size_reg;
    logic [clb_pkg::SIZE_W-1:0]  intent_size_reg;
    logic [clb_pkg::TOTAL_W-1:0] total_reg;
    logic [1:0]                  status_reg;

    // Attribute count register; values above the attribute limit act as the limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= clb_pkg::ATTR_RESET;
        end
        else if (config_write)
        begin
            attr_reg <= config_data;
        end
    end

    assign attr_used = (32'(attr_reg) > MAX_ATTRIBUTES) ?
                       clb_pkg::ATTR_W'(MAX_ATTRIBUTES) : attr_reg;

    always_comb
    begin
        for (int i = 0; i < clb_pkg::SET_W; i++)
        begin
            used_mask[i] = (i < 32'(attr_used));
        end
    end

    // A new item is taken only while the sequencer is idle.
    assign item_stall = !engine_idle;
    assign start      = item_valid && engine_idle;

    clb_engine #(
        .MAX_OBJECTS  (MAX_OBJECTS),
        .MAX_CONCEPTS (MAX_CONCEPTS)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .operation      (operation),
        .attribute_mask (attribute_mask),
        .entry_index    (entry_index),
        .used_mask      (used_mask),
        .idle           (engine_idle),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res            (res)
    );

    // The output register takes a result when it is empty or its transfer completes now.
    assign res_take = res_valid && (!out_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            extent_reg      <= res.extent;
            intent_reg      <= res.intent;
            extent_size_reg <= clb_pkg::popcount(res.extent);
            intent_size_reg <= clb_pkg::popcount(res.intent);
            total_reg       <= res.total;
            status_reg      <= res.status;
        end
    end

    assign result_valid  = out_valid_reg;
    assign extent_bits   = extent_reg;
    assign intent_bits   = intent_reg;
    assign extent_size   = extent_size_reg;
    assign intent_size   = intent_size_reg;
    assign concept_total = total_reg;
    assign status        = status_reg;

    // An accepted item always keeps the sequencer busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item accepted but sequencer still idle");

    // A rejected read never carries entry data.
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == clb_pkg::STAT_INDEX |->
            extent_size == '0 && intent_size == '0)
        else $error("invalid read returned data");

    // A full table is reported only when the table really holds every concept.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == clb_pkg::STAT_FULL |->
            concept_total == clb_pkg::TOTAL_W'(MAX_CONCEPTS))
        else $error("table full reported below capacity");

    // A result is loaded only from a finished item.
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(res_valid))
        else $error("output loaded without a finished item");

endmodule

[dv/concept_lattice_builder_core_test.sv]
// Testbench of concept_lattice_builder_core: random and directed items, scoreboard check.
// Depends on clb_pkg and the design files of the concept lattice builder.
module concept_lattice_builder_core_test;

    // One expected result, with the field widths of the result ports.
    typedef struct {
        logic [clb_pkg::SET_W-1:0]   extent;
        logic [clb_pkg::SET_W-1:0]   intent;
        logic [clb_pkg::SIZE_W-1:0]  extent_pop;
        logic [clb_pkg::SIZE_W-1:0]  intent_pop;
        logic [clb_pkg::TOTAL_W-1:0] total;
        logic [1:0]                  code;
    } lattice_answer_t;

    // The scoreboard keeps its own copy of the concept table and predicts every
    // result at the moment the item transfer is accepted.
    class lattice_scoreboard;
        logic [clb_pkg::SET_W-1:0] intents [clb_pkg::MAX_CONCEPTS_DEF];
        logic [clb_pkg::SET_W-1:0] extents [clb_pkg::MAX_CONCEPTS_DEF];
        int               concepts;
        int               objects;
        int               attr_count;
        int               errors;
        lattice_answer_t  answers [$];

        function new();
            concepts   = 0;
            objects    = 0;
            attr_count = 64;
            errors     = 0;
        endfunction

        function void set_attr_count(input int v);
            attr_count = v;
        endfunction

        function logic [clb_pkg::SET_W-1:0] used_bits();
            int n;
            n = (attr_count > clb_pkg::MAX_ATTRIBUTES_DEF) ?
                clb_pkg::MAX_ATTRIBUTES_DEF : attr_count;
            if (n >= 64)
            begin
                return '1;
            end
            return (64'd1 << n) - 64'd1;
        endfunction

        // Returns the index of the concept with this intent, appending it when
        // absent; -1 means the table is full.
        function int find_or_append(input logic [clb_pkg::SET_W-1:0] intent);
            for (int c = 0; c < concepts; c++)
            begin
                if (intents[c] == intent)
                begin
                    return c;
                end
            end
            if (concepts >= clb_pkg::MAX_CONCEPTS_DEF)
            begin
                return -1;
            end
            intents[concepts] = intent;
            extents[concepts] = '0;
            concepts++;
            return concepts - 1;
        endfunction

        function void note_item(input logic [1:0] op, input logic [clb_pkg::SET_W-1:0] mask,
                                input logic [clb_pkg::INDEX_W-1:0] index);
            lattice_answer_t           a;
            logic [clb_pkg::SET_W-1:0] m;
            logic [clb_pkg::SET_W-1:0] bit_of_object;
            logic [clb_pkg::SET_W-1:0] merged;
            int                        k;
            a.extent = '0;
            a.intent = '0;
            a.code   = clb_pkg::STAT_OK;
            if (op == clb_pkg::OP_ADD)
            begin
                if (objects >= clb_pkg::MAX_OBJECTS_DEF)
                begin
                    a.code = clb_pkg::STAT_LIMIT;
                end
                else
                begin
                    m = mask & used_bits();
                    bit_of_object = 64'd1 << (objects % 64);
                    // Concepts appended in this pass are visited too; the loop
                    // bound grows with the table and they stay unchanged.
                    for (int c = 0; c < concepts; c++)
                    begin
                        merged = extents[c] | bit_of_object;
                        k = find_or_append(intents[c] & m);
                        if (k >= 0)
                        begin
                            extents[k] |= merged;
                        end
                        else
                        begin
                            a.code = clb_pkg::STAT_FULL;
                        end
                    end
                    k = find_or_append(m);
                    if (k >= 0)
                    begin
                        extents[k] |= bit_of_object;
                    end
                    else
                    begin
                        a.code = clb_pkg::STAT_FULL;
                    end
                    objects++;
                end
            end
            else if (op == clb_pkg::OP_CLOSE)
            begin
                if (find_or_append(used_bits()) < 0)
                begin
                    a.code = clb_pkg::STAT_FULL;
                end
            end
            else if (op == clb_pkg::OP_READ)
            begin
                if (index < concepts)
                begin
                    a.extent = extents[index];
                    a.intent = intents[index];
                end
                else
                begin
                    a.code = clb_pkg::STAT_INDEX;
                end
            end
            a.extent_pop = clb_pkg::SIZE_W'($countones(a.extent));
            a.intent_pop = clb_pkg::SIZE_W'($countones(a.intent));
            a.total      = clb_pkg::TOTAL_W'(concepts);
            answers.push_back(a);
        endfunction

        function void check_result(input lattice_answer_t got);
            lattice_answer_t want;
            if (answers.size() == 0)
            begin
                $error("result transfer with no item waiting for it");
                errors++;
                return;
            end
            want = answers.pop_front();
            if (got.extent !== want.extent)
            begin
                $error("extent_bits expected %h got %h", want.extent, got.extent);
                errors++;
            end
            if (got.intent !== want.intent)
            begin
                $error("intent_bits expected %h got %h", want.intent, got.intent);
                errors++;
            end
            if (got.extent_pop !== want.extent_pop)
            begin
                $error("extent_size expected %0d got %0d", want.extent_pop, got.extent_pop);
                errors++;
            end
            if (got.intent_pop !== want.intent_pop)
            begin
                $error("intent_size expected %0d got %0d", want.intent_pop, got.intent_pop);
                errors++;
            end
            if (got.total !== want.total)
            begin
                $error("concept_total expected %0d got %0d", want.total, got.total);
                errors++;
            end
            if (got.code !== want.code)
            begin
                $error("status expected %0d got %0d", want.code, got.code);
                errors++;
            end
        endfunction
    endclass

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000000;
    localparam int HOLD_CYCLES    = 400;

    logic                          clk;
    logic                          rst_n;
    logic                          config_write;
    logic [clb_pkg::ATTR_W-1:0]    config_data;
    logic                          item_valid;
    logic                          item_stall;
    logic [1:0]                    operation;
    logic [clb_pkg::SET_W-1:0]     attribute_mask;
    logic [clb_pkg::INDEX_W-1:0]   entry_index;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic [clb_pkg::SET_W-1:0]     extent_bits;
    logic [clb_pkg::SET_W-1:0]     intent_bits;
    logic [clb_pkg::SIZE_W-1:0]    extent_size;
    logic [clb_pkg::SIZE_W-1:0]    intent_size;
    logic [clb_pkg::TOTAL_W-1:0]   concept_total;
    logic [1:0]                    status;

    lattice_scoreboard sb;
    bit  steady;                  // no random idling on either side while set
    bit  hold_request;            // asks the receiver for one long stall
    bit  hold_started = 1'b0;
    int  hold_off     = 0;        // cycles the receiver still has to stall
    int  quiet_cycles = 0;

    concept_lattice_builder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .config_write   (config_write),
        .config_data    (config_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .attribute_mask (attribute_mask),
        .entry_index    (entry_index),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .extent_bits    (extent_bits),
        .intent_bits    (intent_bits),
        .extent_size    (extent_size),
        .intent_size    (intent_size),
        .concept_total  (concept_total),
        .status         (status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The receiver stalls at random, or for a counted stretch when asked to.
    always @(negedge clk)
    begin
        if (hold_request && !hold_started)
        begin
            hold_started <= 1'b1;
            result_stall <= 1'b1;
            hold_off     <= HOLD_CYCLES - 1;
        end
        else if (hold_off > 0)
        begin
            result_stall <= 1'b1;
            hold_off     <= hold_off - 1;
        end
        else
        begin
            result_stall <= !steady && ($urandom_range(0, 99) < 35);
        end
    end

    // Every accepted result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        lattice_answer_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.extent     = extent_bits;
            got.intent     = intent_bits;
            got.extent_pop = extent_size;
            got.intent_pop = intent_size;
            got.total      = concept_total;
            got.code       = status;
            sb.check_result(got);
        end
    end

    // The watchdog ends the run when no transfer happens for too long; an add on
    // a full table is the slowest item.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("concept_lattice_builder_core verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item, with a random gap first, and waits for its transfer.
    // The valid stays high after the transfer; idle_sender or a random gap in the next call lowers it.
    task automatic send_item(input logic [1:0] op, input logic [clb_pkg::SET_W-1:0] mask,
                             input logic [clb_pkg::INDEX_W-1:0] index);
        while (!steady && $urandom_range(0, 99) < 35)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid     = 1'b1;
        operation      = op;
        attribute_mask = mask;
        entry_index    = index;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
            begin
                break;
            end
        end
        sb.note_item(op, mask, index);
        @(negedge clk);
    endtask

    task automatic idle_sender();
        item_valid = 1'b0;
    endtask

    // Waits until every predicted result has arrived, then lets the block settle.
    task automatic drain();
        idle_sender();
        while (sb.answers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_attr_count(input int v);
        drain();
        config_write = 1'b1;
        config_data  = clb_pkg::ATTR_W'(v);
        @(negedge clk);
        config_write = 1'b0;
        sb.set_attr_count(v);
    endtask

    function automatic logic [clb_pkg::SET_W-1:0] random_mask();
        return {$urandom(), $urandom()};
    endfunction

    // One random item; adds are frequent, closes and no-ops rarer, and
    // reads mostly hit stored entries and sometimes any index at all.
    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            send_item(clb_pkg::OP_ADD, random_mask(), clb_pkg::INDEX_W'($urandom()));
        end
        else if (pick < 40)
        begin
            send_item(clb_pkg::OP_CLOSE, random_mask(), clb_pkg::INDEX_W'($urandom()));
        end
        else if (pick < 45)
        begin
            send_item(OP_NOP, random_mask(), clb_pkg::INDEX_W'($urandom()));
        end
        else if (pick < 85)
        begin
            send_item(clb_pkg::OP_READ, random_mask(),
                      clb_pkg::INDEX_W'($urandom_range(0, sb.concepts)));
        end
        else
        begin
            send_item(clb_pkg::OP_READ, random_mask(), clb_pkg::INDEX_W'($urandom()));
        end
    endtask

    initial
    begin
        int attr_plan [6];
        sb             = new();
        steady         = 1'b0;
        hold_request   = 1'b0;
        rst_n          = 1'b0;
        config_write   = 1'b0;
        config_data    = '0;
        item_valid     = 1'b0;
        operation      = clb_pkg::OP_ADD;
        attribute_mask = '0;
        entry_index    = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset width of 64 attributes: empty table,
        // the no-op code, closing, full and empty masks, and invalid indexes.
        send_item(clb_pkg::OP_READ, '0, '0);
        send_item(OP_NOP, '1, '1);
        send_item(clb_pkg::OP_CLOSE, '0, '0);
        send_item(clb_pkg::OP_READ, '0, '0);
        send_item(clb_pkg::OP_ADD, '1, '0);
        send_item(clb_pkg::OP_ADD, '0, '0);
        send_item(clb_pkg::OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_item(clb_pkg::OP_ADD, 64'h5555_0000_FFFF_0001, '0);
        for (int i = 0; i < 6; i++)
        begin
            send_item(clb_pkg::OP_READ, '0, clb_pkg::INDEX_W'(i));
        end
        send_item(clb_pkg::OP_READ, '0, '1);
        send_item(clb_pkg::OP_CLOSE, '1, '0);

        // The widest setting acts as 64; zero keeps no attribute at all.
        write_attr_count(127);
        send_item(clb_pkg::OP_ADD, 64'h8000_0000_0000_00F0, '0);
        send_item(clb_pkg::OP_CLOSE, '0, '0);
        write_attr_count(0);
        send_item(clb_pkg::OP_ADD, '1, '0);
        send_item(clb_pkg::OP_CLOSE, '0, '0);
        write_attr_count(1);
        send_item(clb_pkg::OP_ADD, '1, '0);
        send_item(clb_pkg::OP_CLOSE, '0, '0);
        send_item(clb_pkg::OP_READ, '0, clb_pkg::INDEX_W'(sb.concepts - 1));

        // Random phases, mostly with few attributes so the table stays small
        // and every add remains cheap.
        attr_plan = '{5, 2, 4, 3, 1, 64};
        for (int p = 0; p < 6; p++)
        begin
            write_attr_count(attr_plan[p]);
            steady = (p == 2);
            if (p == 1)
            begin
                // Receiver holds off while items keep coming, so the output
                // register and the sequencer fill up and the input stalls.
                hold_request = 1'b1;
            end
            for (int i = 0; i < 45; i++)
            begin
                send_random_item();
            end
            steady = 1'b0;
            if (p == 3)
            begin
                // The sender pauses until every outstanding result is back.
                drain();
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (sb.answers.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.answers.size());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("concept_lattice_builder_core verification clean");
        end
        else
        begin
            $display("concept_lattice_builder_core verification failed");
        end
        $finish;
    end

endmodule

[files.f]
design/clb_pkg.sv
design/clb_mem.sv
design/clb_engine.sv
design/concept_lattice_builder_core.sv
dv/concept_lattice_builder_core_test.sv
